// ----- rtl/mpfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfs_pkg: shared types and constants of the elementary stream splitter
// Start code bytes, packet length limits, parse modes and the result bundle
// that the parser hands to the top level.
// ----------------------------------------------------------------------------
package mpfs_pkg;

   // field widths fixed by the interface
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 21;
   localparam int KIND_W = 2;

   // packet length limit and the saturating count that tracks it
   localparam int MAX_PACKET_BYTES = 1048576;
   localparam int COUNT_CAP        = MAX_PACKET_BYTES + 7;
   localparam int COUNT_W          = $clog2(COUNT_CAP + 1);

   localparam logic [COUNT_W-1:0] COUNT_CAP_C   = COUNT_W'(COUNT_CAP);
   localparam logic [COUNT_W-1:0] MAX_BYTES_C   = COUNT_W'(MAX_PACKET_BYTES);
   localparam logic [COUNT_W-1:0] SEQ_HDR_LEN_C = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] PIC_HDR_LEN_C = COUNT_W'(6);

   // byte history: five previous bytes, fill count saturates at five
   localparam int WINDOW_BYTES = 5;
   localparam int FILL_W       = 3;
   localparam logic [FILL_W-1:0] FILL_SEQ_C = FILL_W'(3);
   localparam logic [FILL_W-1:0] FILL_MAX_C = FILL_W'(WINDOW_BYTES);

   // start code bytes
   localparam logic [BYTE_W-1:0] SC_ZERO_C   = 8'h00;
   localparam logic [BYTE_W-1:0] SC_PREFIX_C = 8'h01;
   localparam logic [BYTE_W-1:0] SC_SEQ_C    = 8'hB3;
   localparam logic [BYTE_W-1:0] SC_PIC_C    = 8'h00;

   // picture coding types that open a new packet
   localparam logic [2:0] PTYPE_P_C = 3'd2;
   localparam logic [2:0] PTYPE_B_C = 3'd3;

   typedef enum logic [1:0] {
      MODE_HUNT = 2'd0,
      MODE_SEQ  = 2'd1,
      MODE_PIC  = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_KEY = 2'd0,
      KIND_P   = 2'd1,
      KIND_B   = 2'd2
   } kind_type;

   // one completed packet, valid for the cycle in which it is cut
   typedef struct packed {
      logic              valid;
      logic [LEN_W-1:0]  packet_length;
      kind_type          frame_kind;
      logic              length_overflow;
   } result_type;

endpackage

// ----- rtl/mpfs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfs_if: valid/ready channels of the elementary stream splitter
// Byte input channel and packet report channel, each with source and sink.
// ----------------------------------------------------------------------------
interface mpfs_req_if
   import mpfs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mpfs_rsp_if
   import mpfs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [LEN_W-1:0]  packet_length;
   logic [KIND_W-1:0] frame_kind;
   logic              length_overflow;

   modport source (output valid, output packet_length, output frame_kind,
                   output length_overflow, input ready);
   modport sink   (input valid, input packet_length, input frame_kind,
                   input length_overflow, output ready);
endinterface

// ----- rtl/mpeg2_es_frame_splitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg2_es_frame_splitter_top: MPEG-2 video elementary stream frame splitter
// Scans the stream a byte at a time for sequence and P/B picture start codes
// and reports the length and kind of each packet between them.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | role
//  req_if  | in  | stream_byte                                    | stream bytes
//  rsp_if  | out | packet_length, frame_kind, length_overflow     | packet reports
//
//  One byte per cycle sustained; the scan is a compare against a five-byte
//  history held in registers, done between the input and result registers.
//  A report is held in the result register, loaded when the byte that ends its packet leaves the input register.
//  Synchronous reset clears the history, parse mode and both valid flags.
//  When the result register is held by rsp_if.ready low, bytes still flow
//  until one more cut is found; that byte then waits in the input register.
// ----------------------------------------------------------------------------
module mpeg2_es_frame_splitter_top
   import mpfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   mpfs_req_if.sink   req_if,
   mpfs_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   logic              advance;
   logic              in_ready;
   logic              out_load;

   // scanner and packet state
   mpfs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .result      (result)
   );

   // a byte moves on unless its report finds the result register occupied and rsp_if.ready low
   assign out_load = advance && result.valid;
   assign advance  = in_valid_ff && (!result.valid || !out_valid_ff || rsp_if.ready);
   assign in_ready = !in_valid_ff || advance;
   assign req_if.ready = in_ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_if.valid) begin
         in_byte_ff <= req_if.stream_byte;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.packet_length   = out_ff.packet_length;
   assign rsp_if.frame_kind      = out_ff.frame_kind;
   assign rsp_if.length_overflow = out_ff.length_overflow;

endmodule

// ----- rtl/mpfs_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfs_parser: start code scanner and packet state
// Holds the byte history, parse mode and packet count; flags a cut and its
// report for the byte presented, and updates its state when step is high.
// ----------------------------------------------------------------------------
module mpfs_parser
   import mpfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] stream_byte,
   output result_type        result
);

   logic [WINDOW_BYTES*BYTE_W-1:0] window_ff, window_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   mode_type                       mode_ff, mode_in;
   kind_type                       kind_ff, kind_in;
   logic [COUNT_W-1:0]             count_ff, count_in;

   logic [BYTE_W-1:0]  b1, b2, b3, b4, b5;
   logic [2:0]         ptype;
   logic               seq_hdr, pb_hdr;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] hdr_len;
   logic [COUNT_W-1:0] diff;
   logic               cut;
   kind_type           pb_kind;

   // previous bytes, newest in the low byte
   assign b1    = window_ff[1*BYTE_W-1 -: BYTE_W];
   assign b2    = window_ff[2*BYTE_W-1 -: BYTE_W];
   assign b3    = window_ff[3*BYTE_W-1 -: BYTE_W];
   assign b4    = window_ff[4*BYTE_W-1 -: BYTE_W];
   assign b5    = window_ff[5*BYTE_W-1 -: BYTE_W];
   assign ptype = stream_byte[5:3];

   // start code matches, only over bytes really received
   assign seq_hdr = (fill_ff >= FILL_SEQ_C) && (b3 == SC_ZERO_C) && (b2 == SC_ZERO_C)
                    && (b1 == SC_PREFIX_C) && (stream_byte == SC_SEQ_C);
   assign pb_hdr  = (fill_ff >= FILL_MAX_C) && (b5 == SC_ZERO_C) && (b4 == SC_ZERO_C)
                    && (b3 == SC_PREFIX_C) && (b2 == SC_PIC_C)
                    && ((ptype == PTYPE_P_C) || (ptype == PTYPE_B_C));
   assign pb_kind = (ptype == PTYPE_B_C) ? KIND_B : KIND_P;

   // saturating count including the current byte, counting only in sequence or picture mode
   always_comb begin
      count_inc = count_ff;
      if (((mode_ff == MODE_SEQ) || (mode_ff == MODE_PIC)) && (count_ff < COUNT_CAP_C)) begin
         count_inc = count_ff + COUNT_W'(1);
      end
   end

   // next mode, packet kind and count, and whether this byte cuts a packet
   always_comb begin
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      count_in = count_inc;
      cut      = 1'b0;
      hdr_len  = PIC_HDR_LEN_C;
      case (mode_ff)
         MODE_SEQ: begin
            if (pb_hdr) begin
               cut      = 1'b1;
               mode_in  = MODE_PIC;
               kind_in  = pb_kind;
               count_in = PIC_HDR_LEN_C;
            end
         end
         MODE_PIC: begin
            if (seq_hdr) begin
               cut      = 1'b1;
               hdr_len  = SEQ_HDR_LEN_C;
               mode_in  = MODE_SEQ;
               kind_in  = KIND_KEY;
               count_in = SEQ_HDR_LEN_C;
            end else if (pb_hdr) begin
               cut      = 1'b1;
               kind_in  = pb_kind;
               count_in = PIC_HDR_LEN_C;
            end
         end
         default: begin
            mode_in = MODE_HUNT;
            if (seq_hdr) begin
               mode_in  = MODE_SEQ;
               kind_in  = KIND_KEY;
               count_in = SEQ_HDR_LEN_C;
            end
         end
      endcase
   end

   // report of the packet being closed: length without the new header
   assign diff = count_inc - hdr_len;
   always_comb begin
      result.valid           = cut;
      result.frame_kind      = kind_ff;
      result.length_overflow = (diff > MAX_BYTES_C);
      result.packet_length   = result.length_overflow ? LEN_W'(MAX_BYTES_C) : LEN_W'(diff);
   end

   // byte history and fill
   assign window_in = {window_ff[(WINDOW_BYTES-1)*BYTE_W-1:0], stream_byte};
   assign fill_in   = (fill_ff < FILL_MAX_C) ? fill_ff + FILL_W'(1) : FILL_MAX_C;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
         mode_ff   <= MODE_HUNT;
         kind_ff   <= KIND_KEY;
         count_ff  <= '0;
      end else if (step) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         mode_ff   <= mode_in;
         kind_ff   <= kind_in;
         count_ff  <= count_in;
      end
   end

   // checks
   a_hunt_no_cut: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HUNT) |-> !result.valid)
      else $error("packet cut while hunting for a sequence header");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP_C)
      else $error("packet count beyond its cap");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX_C)
      else $error("window fill beyond five");

   a_cut_stays_locked: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid) |=> (mode_ff != MODE_HUNT) && (count_ff >= SEQ_HDR_LEN_C))
      else $error("cut did not open a new packet");

endmodule
